// ===== sv/twem_pkg.sv =====
package twem_pkg;

	localparam int CNT_W   = 13;
	localparam int SHIFT_W = 3;
	localparam int WGT_W   = 8;
	localparam int IDX_W   = 12;
	localparam int SCALE_W = 7;
	localparam int SUM_W   = 22;
	localparam int QUO_W   = 8;
	localparam int CFG_W   = 13;

	localparam logic [WGT_W-1:0]   WEIGHT_RESET = 8'd128;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 3'd3;
	localparam logic [CNT_W-1:0]   COUNT_RESET  = 13'd4096;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_FILL   = 2'd1,
		OP_MEAN   = 2'd2
	} op_t;

	typedef enum logic {
		REG_SHIFT = 1'b0,
		REG_TILES = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [WGT_W-1:0] sample_value;
		logic [WGT_W-1:0] fill_value;
	} twem_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] tile_index;
		logic [WGT_W-1:0] new_weight;
		logic             frame_done;
		logic [WGT_W-1:0] mean_weight;
	} twem_out_t;

endpackage

// ===== sv/twem_in_if.sv =====
interface twem_in_if;
	import twem_pkg::*;

	logic     valid;
	logic     ready;
	twem_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/twem_out_if.sv =====
interface twem_out_if;
	import twem_pkg::*;

	logic      valid;
	logic      ready;
	twem_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/twem_div.sv =====
// restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits
module twem_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [twem_pkg::SUM_W-1:0]  dividend,
	input  logic [twem_pkg::CNT_W-1:0]  divisor,
	output logic                        done,
	output logic [twem_pkg::QUO_W-1:0]  quotient
);
	import twem_pkg::*;

	localparam int STEP_W = $clog2(QUO_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [QUO_W-1:0]  quo_q;
	logic [SUM_W-1:0]  trial;

	assign trial = SUM_W'(dsr_q) << step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q         <= rem_q - trial;
				quo_q[step_q] <= 1'b1;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== sv/tile_weight_ema_map.sv =====
// Per-tile weight map: one 8-bit exponential moving average per image tile, held in a
// single synchronous RAM of MAX_TILES entries (one write port, one registered read port).
// After reset a clearing pass writes 128 into every entry, one entry a cycle, so the block
// takes no request until the pass is through (configuration writes still land).
// A sample request reads its tile, folds in the sample and writes it back in steps (RAM
// read, update and write, result register); no new request is taken until the last result
// has gone to the output register. A fill sweeps the tiles in use, one write a cycle.
// A mean query streams the tiles in use through an accumulator, then an 8-step
// shift-subtract divider forms the rounded mean. Every request returns exactly one
// result; a result waits in the output register while the next request is taken. Write
// the shift and tile count registers only while idle.
module tile_weight_ema_map #(
	parameter int MAX_TILES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	twem_in_if.sink                     req,
	twem_out_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [twem_pkg::CFG_W-1:0]  cfg_data
);
	import twem_pkg::*;

	// address width of the weight RAM, and a width that holds any tile count
	localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int MW = $clog2(MAX_TILES + 1);
	localparam int IW = (MW > CNT_W) ? MW : CNT_W;

	typedef enum logic [7:0] {
		ST_CLEAR     = 8'b0000_0001,
		ST_IDLE      = 8'b0000_0010,
		ST_SAMPLE    = 8'b0000_0100,
		ST_FILL      = 8'b0000_1000,
		ST_MEAN      = 8'b0001_0000,
		ST_MEAN_LAST = 8'b0010_0000,
		ST_DIV       = 8'b0100_0000,
		ST_EMIT      = 8'b1000_0000
	} state_t;

	function automatic logic [WGT_W-1:0] at_least_one(input logic [WGT_W-1:0] v);
		at_least_one = (v == '0) ? WGT_W'(1) : v;
	endfunction

	// weight storage
	logic [WGT_W-1:0] mem [MAX_TILES];
	logic [WGT_W-1:0] rdata_q;
	logic [AW-1:0]    raddr;
	logic             mem_we;
	logic [AW-1:0]    waddr;
	logic [WGT_W-1:0] wdata;

	// control and configuration
	state_t             state_q;
	logic [AW-1:0]      cnt_q;
	logic [AW-1:0]      pos_q;
	logic [SHIFT_W-1:0] shift_cfg_q;
	logic [CNT_W-1:0]   tiles_cfg_q;

	// request latched for the operation in flight
	logic [AW-1:0]    pos_s1;
	logic [WGT_W-1:0] sample_s1;
	logic [WGT_W-1:0] fill_s1;
	logic [SUM_W-1:0] sum_q;
	twem_out_t        res_q;

	// output register
	logic      out_vld_q;
	twem_out_t out_q;

	logic             req_acc;
	logic [CNT_W-1:0] tiles_n;
	logic [AW-1:0]    pos_eff;
	logic             cnt_end;
	logic             clr_end;
	logic             tile_last;
	logic             emit_go;

	// sample arithmetic
	logic [SHIFT_W-1:0]       shift_eff;
	logic [SCALE_W-1:0]       scale;
	logic [WGT_W+SCALE_W-1:0] prod;
	logic [WGT_W+SCALE_W:0]   acc;
	logic [WGT_W-1:0]         new_w;

	// mean divider
	logic             div_start;
	logic [SUM_W-1:0] div_dividend;
	logic             div_done;
	logic [QUO_W-1:0] div_quo;

	// tiles in use: zero counts as one, large counts saturate at the RAM depth
	always_comb begin
		if (tiles_cfg_q == '0) begin
			tiles_n = CNT_W'(1);
		end else if (IW'(tiles_cfg_q) > IW'(MAX_TILES)) begin
			tiles_n = CNT_W'(MAX_TILES);
		end else begin
			tiles_n = tiles_cfg_q;
		end
	end

	// position left beyond a lowered count restarts at tile zero
	assign pos_eff   = (IW'(pos_q) >= IW'(tiles_n)) ? '0 : pos_q;
	assign cnt_end   = (IW'(cnt_q) == (IW'(tiles_n) - IW'(1)));
	assign clr_end   = (cnt_q == AW'(MAX_TILES - 1));
	assign tile_last = ((IW'(pos_s1) + IW'(1)) >= IW'(tiles_n));

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign emit_go   = (state_q == ST_EMIT) && (!out_vld_q || rsp.ready);

	assign shift_eff = (shift_cfg_q == '0) ? SHIFT_W'(1) : shift_cfg_q;
	assign scale     = SCALE_W'((8'd1 << shift_eff) - 8'd1);
	assign prod      = (WGT_W + SCALE_W)'(at_least_one(rdata_q)) * (WGT_W + SCALE_W)'(scale);
	assign acc       = {1'b0, prod} + (WGT_W + SCALE_W + 1)'(at_least_one(sample_s1));
	assign new_w     = WGT_W'(acc >> shift_eff);

	// read side: the sample tile on acceptance, the running index while averaging
	assign raddr = (state_q == ST_MEAN) ? cnt_q : pos_eff;

	// write side: clearing pass, fill sweep or sample write-back
	always_comb begin
		mem_we = 1'b0;
		waddr  = cnt_q;
		wdata  = WEIGHT_RESET;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_FILL: begin
				mem_we = 1'b1;
				wdata  = fill_s1;
			end
			ST_SAMPLE: begin
				mem_we = 1'b1;
				waddr  = pos_s1;
				wdata  = new_w;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// rounded mean: the last streamed weight and half the count join the sum here
	assign div_start    = (state_q == ST_MEAN_LAST);
	assign div_dividend = sum_q + SUM_W'(at_least_one(rdata_q)) + SUM_W'(tiles_n >> 1);

	twem_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (tiles_n),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_cfg_q <= SHIFT_RESET;
			tiles_cfg_q <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SHIFT: shift_cfg_q <= cfg_data[SHIFT_W-1:0];
				REG_TILES: tiles_cfg_q <= cfg_data[CNT_W-1:0];
				default:   shift_cfg_q <= shift_cfg_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (clr_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (req_acc) begin
						unique case (req.data.operation)
							OP_SAMPLE: state_q <= ST_SAMPLE;
							OP_FILL:   state_q <= ST_FILL;
							OP_MEAN:   state_q <= ST_MEAN;
							default:   state_q <= ST_EMIT;
						endcase
					end
				end
				ST_SAMPLE: begin
					pos_q   <= tile_last ? '0 : pos_s1 + AW'(1);
					state_q <= ST_EMIT;
				end
				ST_FILL: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_end) begin
						pos_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_MEAN: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_end) begin
						state_q <= ST_MEAN_LAST;
					end
				end
				ST_MEAN_LAST: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operands and result of the request in flight
	always_ff @(posedge clk) begin
		if (req_acc) begin
			pos_s1    <= pos_eff;
			sample_s1 <= req.data.sample_value;
			fill_s1   <= (req.data.fill_value == '0) ? WGT_W'(1) : req.data.fill_value;
			sum_q     <= '0;
			res_q     <= '0;
		end else begin
			case (state_q)
				ST_SAMPLE: begin
					res_q.tile_index <= IDX_W'(pos_s1);
					res_q.new_weight <= new_w;
					res_q.frame_done <= tile_last;
				end
				ST_MEAN: begin
					// the first cycle only issues a read
					if (cnt_q != '0) begin
						sum_q <= sum_q + SUM_W'(at_least_one(rdata_q));
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_q.mean_weight <= (div_quo == '0) ? WGT_W'(1) : WGT_W'(div_quo);
					end
				end
				default: begin
					sum_q <= sum_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_go) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import twem_pkg::*;

	localparam int MAX_TILES = 4096;
	// operation code with no function: the block must answer with all fields zero
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 30000;
	localparam int LONG_HOLD = 400;
	localparam int PHASES = 10;
	localparam int PHASE_REQS = 40;
	localparam int DIRECTED_ROWS = 24;

	// one line of the directed table: either a register update or a request,
	// optionally with its result written out by hand
	typedef struct packed {
		logic             cfg_write;
		logic [CFG_W-1:0] shift_v;
		logic [CFG_W-1:0] count_v;
		twem_in_t         req;
		logic             typed;
		twem_out_t        want;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	twem_in_if  req_if ();
	twem_out_if rsp_if ();

	tile_weight_ema_map #(.MAX_TILES(MAX_TILES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// our own copy of the weight map, the running tile position and both registers
	logic [WGT_W-1:0]   tile_weights [MAX_TILES];
	int unsigned        next_tile;
	logic [SHIFT_W-1:0] shift_setting;
	logic [CNT_W-1:0]   count_setting;

	// results owed by the block, oldest first
	twem_out_t   results_due [$];
	twem_out_t   want_now;
	int unsigned mismatches = 0;

	// request side bookkeeping
	bit          offering = 1'b0;
	bit          steady = 1'b0;
	int unsigned burst_left = 0;
	// bumped by the stimulus to make the result side hold off for a long stretch
	int          hold_asks = 0;

	dir_row_t directed_rows [DIRECTED_ROWS];

	// apply one request to the mirror state and return the result it must produce
	function automatic twem_out_t apply_tile_op(input twem_in_t r);
		twem_out_t   res;
		int unsigned n, shift, pos, old_w, smp, nw, total, avg, i;
		res = '0;
		// zero tiles means one, anything past the table saturates
		n = 32'(count_setting);
		if (n == 0)
			n = 1;
		if (n > MAX_TILES)
			n = MAX_TILES;
		case (r.operation)
		OP_SAMPLE: begin
			// a shift of zero acts as one
			shift = (shift_setting == 0) ? 1 : 32'(shift_setting);
			// position left beyond a lowered tile count wraps to tile 0
			pos = (next_tile >= n) ? 0 : next_tile;
			old_w = (tile_weights[pos] > 1) ? 32'(tile_weights[pos]) : 1;
			smp = (r.sample_value > 1) ? 32'(r.sample_value) : 1;
			nw = (old_w * ((1 << shift) - 1) + smp) >> shift;
			tile_weights[pos] = nw[WGT_W-1:0];
			res.tile_index = pos[IDX_W-1:0];
			res.new_weight = nw[WGT_W-1:0];
			if (pos + 1 >= n) begin
				res.frame_done = 1'b1;
				next_tile = 0;
			end else
				next_tile = pos + 1;
		end
		OP_FILL: begin
			for (i = 0; i < n; i++)
				tile_weights[i] = (r.fill_value == 0) ? 8'd1 : r.fill_value;
			next_tile = 0;
		end
		OP_MEAN: begin
			total = 0;
			for (i = 0; i < n; i++)
				total += (tile_weights[i] > 1) ? 32'(tile_weights[i]) : 1;
			avg = (total + n / 2) / n;
			if (avg == 0)
				avg = 1;
			res.mean_weight = avg[WGT_W-1:0];
		end
		default: ;
		endcase
		return res;
	endfunction

	function automatic dir_row_t cfg_row(input int unsigned shift_v, input int unsigned count_v);
		dir_row_t r;
		r = '0;
		r.cfg_write = 1'b1;
		r.shift_v = shift_v[CFG_W-1:0];
		r.count_v = count_v[CFG_W-1:0];
		return r;
	endfunction

	function automatic dir_row_t req_row(input logic [1:0] op, input logic [WGT_W-1:0] s,
			input logic [WGT_W-1:0] f);
		dir_row_t r;
		r = '0;
		r.req.operation = op;
		r.req.sample_value = s;
		r.req.fill_value = f;
		return r;
	endfunction

	function automatic dir_row_t typed_row(input logic [1:0] op, input logic [WGT_W-1:0] s,
			input logic [WGT_W-1:0] f, input twem_out_t want);
		dir_row_t r;
		r = req_row(op, s, f);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	// byte values leaning on the extremes
	function automatic logic [WGT_W-1:0] pick_byte();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		2: return 8'd1;
		default: return WGT_W'($urandom);
		endcase
	endfunction

	// random request; with a large table fills and means are slow, so keep them rare
	function automatic twem_in_t pick_request(input bit slow);
		twem_in_t    r;
		int unsigned roll;
		r.sample_value = pick_byte();
		r.fill_value = pick_byte();
		roll = $urandom_range(0, 99);
		if (slow)
			r.operation = (roll < 92) ? OP_SAMPLE : (roll < 95) ? OP_FILL :
				(roll < 98) ? OP_MEAN : OP_UNUSED;
		else
			r.operation = (roll < 62) ? OP_SAMPLE : (roll < 74) ? OP_FILL :
				(roll < 94) ? OP_MEAN : OP_UNUSED;
		return r;
	endfunction

	// offer one request, record its result at the accepting edge, then maybe pause
	// valid is left high unless it pauses, so back-to-back requests never toggle it
	task automatic issue_request(input twem_in_t item, input bit typed, input twem_out_t want);
		twem_out_t   computed;
		int unsigned gap;
		req_if.valid <= 1'b1;
		req_if.data <= item;
		offering = 1'b1;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		computed = apply_tile_op(item);
		results_due.push_back(typed ? want : computed);
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(1, 24);
			if (!steady) begin
				gap = $urandom_range(1, 8);
				req_if.valid <= 1'b0;
				offering = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop offering and wait for every owed result, then a few quiet cycles
	task automatic drain_results(input int unsigned settle);
		if (offering) begin
			req_if.valid <= 1'b0;
			offering = 1'b0;
		end
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// write both registers on consecutive edges
	task automatic set_config(input logic [CFG_W-1:0] shift_v, input logic [CFG_W-1:0] count_v);
		cfg_we <= 1'b1;
		cfg_index <= REG_SHIFT;
		cfg_data <= shift_v;
		@(posedge clk);
		shift_setting = shift_v[SHIFT_W-1:0];
		cfg_index <= REG_TILES;
		cfg_data <= count_v;
		@(posedge clk);
		count_setting = count_v;
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	initial begin : stimulus
		dir_row_t         row;
		logic [CFG_W-1:0] shift_plan [PHASES];
		logic [CFG_W-1:0] count_plan [PHASES];
		int unsigned      ph, k;

		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SHIFT;
		cfg_data = '0;

		// mirror starts where the block comes out of reset
		for (k = 0; k < MAX_TILES; k++)
			tile_weights[k] = WEIGHT_RESET;
		next_tile = 0;
		shift_setting = SHIFT_RESET;
		count_setting = COUNT_RESET;

		// phase settings: shift of zero, both shift extremes, zero tiles,
		// full table and a count above the table
		shift_plan = '{13'd1, 13'd7, 13'd0, 13'd4, 13'd2, 13'd5, 13'd6, 13'd3, 13'd7, 13'd1};
		count_plan = '{13'd1, 13'd0, 13'd3, 13'd16, 13'd4096, 13'd7, 13'd8191, 13'd2,
			13'd31, 13'd5};

		directed_rows = '{
			// whole table is 128 after reset
			typed_row(OP_MEAN, 8'd0, 8'd0, twem_out_t'{12'd0, 8'd0, 1'b0, 8'd128}),
			// shift zero acts as one, zero tiles acts as one tile
			cfg_row(0, 0),
			// (128 + 1) >> 1, single tile so every sample ends the frame
			typed_row(OP_SAMPLE, 8'd0, 8'd0, twem_out_t'{12'd0, 8'd64, 1'b1, 8'd0}),
			req_row(OP_MEAN, 8'd255, 8'd255),
			cfg_row(7, 4),
			// fill of zero stores one
			typed_row(OP_FILL, 8'd0, 8'd0, '0),
			typed_row(OP_MEAN, 8'd0, 8'd0, twem_out_t'{12'd0, 8'd0, 1'b0, 8'd1}),
			req_row(OP_SAMPLE, 8'd255, 8'd0),
			req_row(OP_SAMPLE, 8'd0, 8'd255),
			req_row(OP_SAMPLE, 8'd128, 8'd0),
			req_row(OP_SAMPLE, 8'd1, 8'd0),
			typed_row(OP_FILL, 8'd0, 8'd255, '0),
			// full-scale weight and sample stay at 255
			typed_row(OP_SAMPLE, 8'd255, 8'd0, twem_out_t'{12'd0, 8'd255, 1'b0, 8'd0}),
			req_row(OP_SAMPLE, 8'd255, 8'd0),
			// unused operation answers with zeros and changes nothing
			typed_row(OP_UNUSED, 8'd255, 8'd255, '0),
			typed_row(OP_MEAN, 8'd0, 8'd0, twem_out_t'{12'd0, 8'd0, 1'b0, 8'd255}),
			// position is now 2, past the new count: next sample goes to tile 0
			cfg_row(3, 2),
			req_row(OP_SAMPLE, 8'd0, 8'd0),
			req_row(OP_SAMPLE, 8'd77, 8'd0),
			// count above the table saturates
			cfg_row(3, 8191),
			req_row(OP_MEAN, 8'd0, 8'd0),
			typed_row(OP_FILL, 8'd0, 8'd1, '0),
			cfg_row(7, 4096),
			typed_row(OP_MEAN, 8'd0, 8'd0, twem_out_t'{12'd0, 8'd0, 1'b0, 8'd1})
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed table; register rows wait for the block to go idle first
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.cfg_write) begin
				drain_results(4);
				set_config(row.shift_v, row.count_v);
			end else
				issue_request(row.req, row.typed, row.want);
		end

		// random phases, one register setting each; every third phase runs without gaps
		for (ph = 0; ph < PHASES; ph++) begin
			drain_results(4);
			set_config(shift_plan[ph], count_plan[ph]);
			steady = (ph % 3 == 1);
			// long result-side hold while requests keep coming, so the block backs up
			if (ph == 3)
				hold_asks <= hold_asks + 1;
			for (k = 0; k < PHASE_REQS; k++)
				issue_request(pick_request(count_setting > 64), 1'b0, '0);
		end

		drain_results(20);
		if (mismatches == 0 && results_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// result side: ready follows a 16-bit pattern that is redrawn periodically,
	// with an occasional long hold on request from the stimulus
	initial begin : result_sink
		logic [15:0] pattern;
		int unsigned hold_left, slot;
		int          seen;
		rsp_if.ready = 1'b0;
		pattern = '1;
		hold_left = 0;
		slot = 0;
		seen = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != seen) begin
				seen = hold_asks;
				hold_left = LONG_HOLD;
			end
			if (slot % 64 == 0) begin
				case ($urandom_range(0, 3))
				0: pattern = '1;
				1: pattern = 16'($urandom);
				2: pattern = 16'($urandom | $urandom);
				default: pattern = 16'h00FF << $urandom_range(0, 8);
				endcase
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else
				rsp_if.ready <= pattern[slot[3:0]];
			slot++;
		end
	end

	// compare each accepted result against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none got index %0d weight %0d done %0d mean %0d",
					$time, rsp_if.data.tile_index, rsp_if.data.new_weight,
					rsp_if.data.frame_done, rsp_if.data.mean_weight);
				mismatches++;
			end else begin
				want_now = results_due.pop_front();
				check_field("tile_index", 32'(want_now.tile_index),
					32'(rsp_if.data.tile_index));
				check_field("new_weight", 32'(want_now.new_weight),
					32'(rsp_if.data.new_weight));
				check_field("frame_done", 32'(want_now.frame_done),
					32'(rsp_if.data.frame_done));
				check_field("mean_weight", 32'(want_now.mean_weight),
					32'(rsp_if.data.mean_weight));
			end
		end
	end

	// give up after a long stretch with no request or result moving;
	// covers the clearing pass after reset and a full-table mean
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILED: results differ");
		$finish;
	end

endmodule
